FILE: design/range_list_to_tor_slot_compiler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range list to TOR slot compiler
// Each macro checks a property on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef RANGE_LIST_TO_TOR_SLOT_COMPILER_ASSERT_SVH
`define RANGE_LIST_TO_TOR_SLOT_COMPILER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants of the range list to TOR slot compiler.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

  localparam int DEF_MAX_SLOTS = 32;
  localparam int DEF_MIN_ALIGN = 4096;
  localparam int RESULT_CAP    = 32;
  localparam int CNT_W         = 7;
  localparam int ENTRY_W       = 192;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ALIGN   = 3'd1;
  localparam logic [2:0] ST_WRAP    = 3'd2;
  localparam logic [2:0] ST_OVERLAP = 3'd3;
  localparam logic [2:0] ST_NOSLOT  = 3'd4;

  localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
  localparam logic [1:0] REG_FULL_EN    = 2'd1;
  localparam logic [1:0] REG_FULL_PERM  = 2'd2;

  // One finished list handed from the loader to the compile engine.
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [2:0]       err;
  } job_t;

endpackage

`default_nettype wire

FILE: design/trc_ram.sv
// ----------------------------------------------------------------------------
// trc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/trc_load.sv
// ----------------------------------------------------------------------------
// trc_load
// Front end: checks each range, stores good ones and queues a compile job.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_load #(
  parameter int MAX_SLOTS = 32,
  parameter int MIN_ALIGN = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         has_range,
  input  wire logic [63:0]                  base_addr,
  input  wire logic [63:0]                  range_size,
  input  wire logic [63:0]                  perm_word,
  input  wire logic                         last,
  output logic                              we,
  output logic [$clog2(MAX_SLOTS)-1:0]      waddr,
  output logic [trc_pkg::ENTRY_W-1:0]       wdata,
  input  wire logic                         busy,
  input  wire logic                         job_pop,
  output logic                              job_valid,
  output trc_pkg::job_t                     job
);
  import trc_pkg::*;

  localparam int          AW         = $clog2(MAX_SLOTS);
  localparam logic [63:0] ALIGN_MASK = 64'(MIN_ALIGN - 1);

  logic [CNT_W-1:0] cnt;
  logic [2:0]       lerr;
  logic             accept;
  logic             bad;
  logic             full;
  logic             store;
  logic [CNT_W-1:0] cnt_next;
  logic [2:0]       lerr_next;

  assign in_ready = !job_valid && !busy;
  assign accept   = in_valid && in_ready;

  assign bad   = has_range && ((range_size == 64'd0) || ((base_addr & ALIGN_MASK) != 64'd0)
                               || ((range_size & ALIGN_MASK) != 64'd0));
  assign full  = has_range && !bad && (cnt >= CNT_W'(MAX_SLOTS));
  assign store = has_range && !bad && !full;

  always_comb begin
    cnt_next  = cnt + CNT_W'(store);
    lerr_next = lerr;
    if (lerr == ST_OK) begin
      if (bad) begin
        lerr_next = ST_ALIGN;
      end else if (full) begin
        lerr_next = ST_NOSLOT;
      end
    end
  end

  assign we    = accept && store;
  assign waddr = cnt[AW-1:0];
  assign wdata = {perm_word, range_size, base_addr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      lerr      <= ST_OK;
      job_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (last) begin
          job_valid <= 1'b1;
          job.n     <= cnt_next;
          job.err   <= lerr_next;
          cnt       <= '0;
          lerr      <= ST_OK;
        end else begin
          cnt  <= cnt_next;
          lerr <= lerr_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/trc_compile.sv
// ----------------------------------------------------------------------------
// trc_compile
// Back end: sorts stored ranges by scanning, checks and merges them, and
// emits slot writes through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_list_to_tor_slot_compiler_assert.svh"

module trc_compile #(
  parameter int MAX_SLOTS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [5:0]                   sc,
  input  wire logic                         full_en,
  input  wire logic [63:0]                  full_perm,
  input  wire logic                         job_valid,
  input  wire trc_pkg::job_t                job,
  output logic                              job_pop,
  output logic                              busy,
  output logic [$clog2(MAX_SLOTS)-1:0]      raddr,
  input  wire logic [trc_pkg::ENTRY_W-1:0]  rdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [5:0]                        slot_index,
  output logic                              addr_written,
  output logic [61:0]                       slot_addr,
  output logic [63:0]                       slot_perm,
  output logic                              slot_mode,
  output logic [2:0]                        status,
  output logic                              last_result
);
  import trc_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NEXT    = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_STEP    = 4'd3;
  localparam logic [3:0] S_FLUSH   = 4'd4;
  localparam logic [3:0] S_FTOR    = 4'd5;
  localparam logic [3:0] S_ADV     = 4'd6;
  localparam logic [3:0] S_PASSEND = 4'd7;
  localparam logic [3:0] S_TAIL    = 4'd8;
  localparam logic [3:0] S_ERR     = 4'd9;

  logic [3:0]       state;
  logic [CNT_W-1:0] job_n;
  logic [CNT_W-1:0] k;
  logic [CNT_W-1:0] scan_i;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pend;
  logic [63:0]      best_base;
  logic [63:0]      best_size;
  logic [63:0]      best_perm;
  logic [CNT_W-1:0] best_idx;
  logic             best_valid;
  logic [63:0]      pk_base;
  logic [CNT_W-1:0] pk_idx;
  logic             pk_valid;
  logic [63:0]      cur_base;
  logic [63:0]      cur_end;
  logic [63:0]      cur_perm;
  logic             cur_valid;
  logic [63:0]      emitted_end;
  logic             flushed;
  logic [6:0]       need;
  logic [5:0]       slot;
  logic             pass;
  logic             end_flush;
  logic [2:0]       err_code;
  logic             fr;

  logic [63:0]      r_base;
  logic [63:0]      r_size;
  logic [63:0]      r_perm;
  logic             cand;
  logic [64:0]      sum;
  logic             off_needed;
  logic             out_free;
  logic             emit;

  assign r_base = rdata[63:0];
  assign r_size = rdata[127:64];
  assign r_perm = rdata[191:128];

  // Next in sorted order: key (base, index) above the last one taken,
  // lowest among those seen so far. Ties keep load order.
  assign cand = (!pk_valid || (r_base > pk_base) || ((r_base == pk_base) && (rd_idx > pk_idx)))
                && (!best_valid || (r_base < best_base));

  assign sum        = {1'b0, best_base} + {1'b0, best_size};
  assign off_needed = !flushed || (cur_base != emitted_end);
  assign out_free   = !out_valid || out_ready;
  // A new result is loaded into the output register this cycle.
  assign emit       = out_free && (((state == S_FLUSH) && pass && off_needed)
                                   || (state == S_FTOR) || (state == S_TAIL)
                                   || (state == S_ERR));
  assign raddr      = scan_i[AW-1:0];
  assign job_pop    = (state == S_IDLE) && job_valid;
  assign busy       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            job_n       <= job.n;
            k           <= '0;
            pk_valid    <= 1'b0;
            cur_valid   <= 1'b0;
            flushed     <= 1'b0;
            emitted_end <= '0;
            need        <= '0;
            slot        <= 6'd1;
            pass        <= 1'b0;
            end_flush   <= 1'b0;
            fr          <= full_en;
            if (full_en) begin
              state <= S_TAIL;
            end else if (job.err != ST_OK) begin
              err_code <= job.err;
              state    <= S_ERR;
            end else if (job.n > {1'b0, sc}) begin
              err_code <= ST_NOSLOT;
              state    <= S_ERR;
            end else if (job.n == '0) begin
              state <= S_TAIL;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (k < job_n) begin
            scan_i     <= '0;
            rd_pend    <= 1'b0;
            best_valid <= 1'b0;
            state      <= S_SCAN;
          end else begin
            end_flush <= 1'b1;
            state     <= S_FLUSH;
          end
        end
        S_SCAN: begin
          rd_pend <= (scan_i < job_n);
          rd_idx  <= scan_i;
          if (scan_i < job_n) begin
            scan_i <= scan_i + CNT_W'(1);
          end
          if (rd_pend && cand) begin
            best_base  <= r_base;
            best_size  <= r_size;
            best_perm  <= r_perm;
            best_idx   <= rd_idx;
            best_valid <= 1'b1;
          end
          if ((scan_i == job_n) && !rd_pend) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          k        <= k + CNT_W'(1);
          pk_base  <= best_base;
          pk_idx   <= best_idx;
          pk_valid <= 1'b1;
          if (!pass && sum[64]) begin
            err_code <= ST_WRAP;
            state    <= S_ERR;
          end else if (!pass && cur_valid && (best_base < cur_end)) begin
            err_code <= ST_OVERLAP;
            state    <= S_ERR;
          end else if (cur_valid && (best_base == cur_end) && (best_perm == cur_perm)) begin
            cur_end <= sum[63:0];
            state   <= S_NEXT;
          end else if (cur_valid) begin
            state <= S_FLUSH;
          end else begin
            cur_base  <= best_base;
            cur_end   <= sum[63:0];
            cur_perm  <= best_perm;
            cur_valid <= 1'b1;
            state     <= S_NEXT;
          end
        end
        S_FLUSH: begin
          if (!pass) begin
            need        <= need + (off_needed ? 7'd2 : 7'd1);
            emitted_end <= cur_end;
            flushed     <= 1'b1;
            state       <= S_ADV;
          end else if (!off_needed) begin
            state <= S_FTOR;
          end else if (out_free) begin
            out_valid    <= 1'b1;
            slot_index   <= slot;
            addr_written <= 1'b1;
            slot_addr    <= cur_base[63:2];
            slot_perm    <= '0;
            slot_mode    <= 1'b0;
            status       <= ST_OK;
            last_result  <= 1'b0;
            slot         <= slot + 6'd1;
            state        <= S_FTOR;
          end
        end
        S_FTOR: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            slot_index   <= slot;
            addr_written <= 1'b1;
            slot_addr    <= cur_end[63:2];
            slot_perm    <= cur_perm;
            slot_mode    <= 1'b1;
            status       <= ST_OK;
            last_result  <= 1'b0;
            slot         <= slot + 6'd1;
            emitted_end  <= cur_end;
            flushed      <= 1'b1;
            state        <= S_ADV;
          end
        end
        S_ADV: begin
          if (end_flush) begin
            state <= S_PASSEND;
          end else begin
            cur_base  <= best_base;
            cur_end   <= sum[63:0];
            cur_perm  <= best_perm;
            cur_valid <= 1'b1;
            state     <= S_NEXT;
          end
        end
        S_PASSEND: begin
          if (pass) begin
            state <= S_TAIL;
          end else if (need > (7'(sc) - 7'd1)) begin
            err_code <= ST_NOSLOT;
            state    <= S_ERR;
          end else begin
            k           <= '0;
            pk_valid    <= 1'b0;
            cur_valid   <= 1'b0;
            flushed     <= 1'b0;
            emitted_end <= '0;
            slot        <= 6'd1;
            pass        <= 1'b1;
            end_flush   <= 1'b0;
            state       <= S_NEXT;
          end
        end
        S_TAIL: begin
          if (out_free) begin
            out_valid <= 1'b1;
            slot_addr <= '0;
            status    <= ST_OK;
            if (slot < sc) begin
              slot_index   <= slot;
              addr_written <= 1'b1;
              slot_perm    <= '0;
              slot_mode    <= 1'b0;
              last_result  <= 1'b0;
              slot         <= slot + 6'd1;
            end else begin
              slot_index   <= sc;
              addr_written <= 1'b0;
              slot_perm    <= fr ? full_perm : 64'd0;
              slot_mode    <= fr;
              last_result  <= 1'b1;
              state        <= S_IDLE;
            end
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            slot_index   <= '0;
            addr_written <= 1'b0;
            slot_addr    <= '0;
            slot_perm    <= '0;
            slot_mode    <= 1'b0;
            status       <= err_code;
            last_result  <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TRC_ASSERT_NOW(a_err_single, out_valid && (status != ST_OK), last_result && (slot_index == 6'd0), "error result must be a lone final result")
  `TRC_ASSERT_NEXT(a_pop_starts, job_pop, state != S_IDLE, "a popped job must start the engine")
  `TRC_ASSERT_NOW(a_slot_range, out_valid && (status == ST_OK), (slot_index != 6'd0) && (slot_index <= sc), "slot index out of range")

endmodule

`default_nettype wire

FILE: design/range_list_to_tor_slot_compiler.sv
// Loading: good ranges are stored as taken; an item without last gives no result.
// Compile: two passes, each paced by the selection scan over the single read port of
// the range table; slot writes leave at up to one per cycle as the receiver allows.
// Throughput: one item per cycle while loading; no item is taken while a compile runs.
// Reset: synchronous, active high; clears counts, errors, the job queue and output valid.
// ----------------------------------------------------------------------------
// range_list_to_tor_slot_compiler
// Loads protected ranges and compiles them into top-of-range slot writes.
// ----------------------------------------------------------------------------
`default_nettype none

module range_list_to_tor_slot_compiler #(
  parameter int MAX_SLOTS = trc_pkg::DEF_MAX_SLOTS,
  parameter int MIN_ALIGN = trc_pkg::DEF_MIN_ALIGN
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        has_range,
  input  wire logic [63:0] base_addr,
  input  wire logic [63:0] range_size,
  input  wire logic [63:0] perm_word,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       slot_index,
  output logic             addr_written,
  output logic [61:0]      slot_addr,
  output logic [63:0]      slot_perm,
  output logic             slot_mode,
  output logic [2:0]       status,
  output logic             last_result
);
  import trc_pkg::*;

  localparam int         AW      = $clog2(MAX_SLOTS);
  localparam int         SC_LIM  = (MAX_SLOTS < RESULT_CAP) ? MAX_SLOTS : RESULT_CAP;
  localparam logic [5:0] SC_MAX  = 6'(SC_LIM);

  logic [5:0]         slot_total;
  logic               full_rule_enable;
  logic [63:0]        full_rule_perm;
  logic [5:0]         sc_eff;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic               busy;
  logic               job_pop;
  logic               job_valid;
  job_t               job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_total       <= 6'd32;
      full_rule_enable <= 1'b0;
      full_rule_perm   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SLOT_COUNT: slot_total       <= cfg_data[5:0];
        REG_FULL_EN:    full_rule_enable <= cfg_data[0];
        REG_FULL_PERM:  full_rule_perm   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Zero acts as one slot; larger values are clamped to the slot limit.
  always_comb begin
    if (slot_total == 6'd0) begin
      sc_eff = 6'd1;
    end else if (slot_total > SC_MAX) begin
      sc_eff = SC_MAX;
    end else begin
      sc_eff = slot_total;
    end
  end

  trc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  trc_load #(
    .MAX_SLOTS (MAX_SLOTS),
    .MIN_ALIGN (MIN_ALIGN)
  ) u_load (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .has_range  (has_range),
    .base_addr  (base_addr),
    .range_size (range_size),
    .perm_word  (perm_word),
    .last       (last),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .busy       (busy),
    .job_pop    (job_pop),
    .job_valid  (job_valid),
    .job        (job)
  );

  trc_compile #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_compile (
    .clk          (clk),
    .rst          (rst),
    .sc           (sc_eff),
    .full_en      (full_rule_enable),
    .full_perm    (full_rule_perm),
    .job_valid    (job_valid),
    .job          (job),
    .job_pop      (job_pop),
    .busy         (busy),
    .raddr        (raddr),
    .rdata        (rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot_index   (slot_index),
    .addr_written (addr_written),
    .slot_addr    (slot_addr),
    .slot_perm    (slot_perm),
    .slot_mode    (slot_mode),
    .status       (status),
    .last_result  (last_result)
  );

endmodule

`default_nettype wire

FILE: tb/range_list_to_tor_slot_compiler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_list_to_tor_slot_compiler_test
// Feeds lists of protected ranges through the compiler under several slot
// counts and full-rule settings. It predicts every slot write and error
// result, and checks each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module range_list_to_tor_slot_compiler_test;
  import trc_pkg::*;

  localparam int TABLE_DEPTH = 32;
  localparam logic [63:0] PAGE_MASK = 64'd4095;

  typedef struct packed {
    logic        has_range;
    logic [63:0] base_addr;
    logic [63:0] range_size;
    logic [63:0] perm_word;
    logic        last;
  } range_item_t;

  typedef struct packed {
    logic [5:0]  slot_index;
    logic        addr_written;
    logic [61:0] slot_addr;
    logic [63:0] slot_perm;
    logic        slot_mode;
    logic [2:0]  status;
    logic        last_result;
  } slot_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;
  logic in_valid, in_ready;
  logic has_range, last;
  logic [63:0] base_addr, range_size, perm_word;
  logic out_valid, out_ready;
  logic [5:0] slot_index;
  logic addr_written, slot_mode, last_result;
  logic [61:0] slot_addr;
  logic [63:0] slot_perm;
  logic [2:0] status;

  range_list_to_tor_slot_compiler dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .has_range(has_range), .base_addr(base_addr),
    .range_size(range_size), .perm_word(perm_word), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .slot_index(slot_index),
    .addr_written(addr_written), .slot_addr(slot_addr), .slot_perm(slot_perm),
    .slot_mode(slot_mode), .status(status), .last_result(last_result)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [63:0] tbl_base [TABLE_DEPTH];
  logic [63:0] tbl_size [TABLE_DEPTH];
  logic [63:0] tbl_perm [TABLE_DEPTH];
  int unsigned stored_ranges;
  logic [2:0]  pending_error;
  logic [5:0]  cfg_slots;
  logic        cfg_full_en;
  logic [63:0] cfg_full_perm;

  slot_write_t slot_writes_due[$];
  range_item_t items_to_send[$];
  int unsigned mismatches;
  int unsigned hold_request;

  function automatic slot_write_t mk_write(int unsigned idx, logic aw, logic [63:0] addr,
                                          logic [63:0] perm, logic mode, logic [2:0] st,
                                          logic lr);
    slot_write_t w;
    w.slot_index   = idx[5:0];
    w.addr_written = aw;
    w.slot_addr    = addr[61:0];
    w.slot_perm    = perm;
    w.slot_mode    = mode;
    w.status       = st;
    w.last_result  = lr;
    return w;
  endfunction

  task automatic compile_slots();
    logic [63:0] rb [TABLE_DEPTH];
    logic [63:0] rs [TABLE_DEPTH];
    logic [63:0] rp [TABLE_DEPTH];
    logic [63:0] tb_, ts_, tp_, fin, prev_fin;
    int unsigned n, sc, cnt, need, slot, i, j;
    bit failed;
    n = stored_ranges;
    sc = (cfg_slots == 0) ? 1 : (cfg_slots > 32 ? 32 : cfg_slots);
    failed = 0;
    if (cfg_full_en) begin
      for (slot = 1; slot < sc; slot++)
        slot_writes_due.push_back(mk_write(slot, 1'b1, 64'd0, 64'd0, 1'b0, ST_OK, 1'b0));
      slot_writes_due.push_back(mk_write(sc, 1'b0, 64'd0, cfg_full_perm, 1'b1, ST_OK, 1'b1));
      return;
    end
    if (pending_error != ST_OK) begin
      slot_writes_due.push_back(mk_write(0, 1'b0, 64'd0, 64'd0, 1'b0, pending_error, 1'b1));
      return;
    end
    if (n > sc) begin
      slot_writes_due.push_back(mk_write(0, 1'b0, 64'd0, 64'd0, 1'b0, ST_NOSLOT, 1'b1));
      return;
    end
    // Stable insertion sort by base.
    for (i = 0; i < n; i++) begin
      tb_ = tbl_base[i]; ts_ = tbl_size[i]; tp_ = tbl_perm[i];
      j = i;
      while (j > 0 && rb[j-1] > tb_) begin
        rb[j] = rb[j-1]; rs[j] = rs[j-1]; rp[j] = rp[j-1];
        j--;
      end
      rb[j] = tb_; rs[j] = ts_; rp[j] = tp_;
    end
    cnt = 0;
    for (i = 0; i < n && !failed; i++) begin
      fin = rb[i] + rs[i];
      if (fin <= rb[i]) begin
        slot_writes_due.push_back(mk_write(0, 1'b0, 64'd0, 64'd0, 1'b0, ST_WRAP, 1'b1));
        failed = 1;
      end else if (cnt > 0 && rb[i] < rb[cnt-1] + rs[cnt-1]) begin
        slot_writes_due.push_back(mk_write(0, 1'b0, 64'd0, 64'd0, 1'b0, ST_OVERLAP, 1'b1));
        failed = 1;
      end else if (cnt > 0 && rb[i] == rb[cnt-1] + rs[cnt-1] && rp[i] == rp[cnt-1]) begin
        rs[cnt-1] += rs[i];
      end else begin
        rb[cnt] = rb[i]; rs[cnt] = rs[i]; rp[cnt] = rp[i];
        cnt++;
      end
    end
    if (failed) return;
    need = 0;
    prev_fin = 0;
    for (i = 0; i < cnt; i++) begin
      if (i == 0 || rb[i] != prev_fin) need++;
      need++;
      prev_fin = rb[i] + rs[i];
    end
    if (need > sc - 1) begin
      slot_writes_due.push_back(mk_write(0, 1'b0, 64'd0, 64'd0, 1'b0, ST_NOSLOT, 1'b1));
      return;
    end
    slot = 1;
    prev_fin = 0;
    for (i = 0; i < cnt; i++) begin
      fin = rb[i] + rs[i];
      if (i == 0 || rb[i] != prev_fin) begin
        slot_writes_due.push_back(mk_write(slot, 1'b1, rb[i] >> 2, 64'd0, 1'b0, ST_OK, 1'b0));
        slot++;
      end
      slot_writes_due.push_back(mk_write(slot, 1'b1, fin >> 2, rp[i], 1'b1, ST_OK, 1'b0));
      slot++;
      prev_fin = fin;
    end
    for (; slot < sc; slot++)
      slot_writes_due.push_back(mk_write(slot, 1'b1, 64'd0, 64'd0, 1'b0, ST_OK, 1'b0));
    slot_writes_due.push_back(mk_write(sc, 1'b0, 64'd0, 64'd0, 1'b0, ST_OK, 1'b1));
  endtask

  task automatic load_range(range_item_t it);
    if (it.has_range) begin
      if (it.range_size == 0 || (it.base_addr & PAGE_MASK) != 0 ||
          (it.range_size & PAGE_MASK) != 0) begin
        if (pending_error == ST_OK) pending_error = ST_ALIGN;
      end else if (stored_ranges >= TABLE_DEPTH) begin
        if (pending_error == ST_OK) pending_error = ST_NOSLOT;
      end else begin
        tbl_base[stored_ranges] = it.base_addr;
        tbl_size[stored_ranges] = it.range_size;
        tbl_perm[stored_ranges] = it.perm_word;
        stored_ranges++;
      end
    end
    if (it.last) begin
      compile_slots();
      stored_ranges = 0;
      pending_error = ST_OK;
    end
  endtask

  // Input driver.
  range_item_t cur_item;
  int unsigned send_gap;
  initial begin
    in_valid <= 1'b0; has_range <= 1'b0; base_addr <= '0; range_size <= '0;
    perm_word <= '0; last <= 1'b0;
    send_gap = 0;
  end

  always @(posedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        load_range(cur_item);
        next_valid = 1'b0;
        send_gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (items_to_send.size() > 0) begin
          cur_item = items_to_send.pop_front();
          has_range  <= cur_item.has_range;
          base_addr  <= cur_item.base_addr;
          range_size <= cur_item.range_size;
          perm_word  <= cur_item.perm_word;
          last       <= cur_item.last;
          next_valid = 1'b1;
        end
      end
    end
    in_valid <= next_valid;
  end

  // Result monitor and receiver stalls.
  int unsigned recv_gap, recv_hold;
  initial begin
    out_ready <= 1'b0;
    recv_gap = 0;
    recv_hold = 0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    slot_write_t got, want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {slot_index, addr_written, slot_addr, slot_perm, slot_mode, status, last_result};
        if (slot_writes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", got);
        end else begin
          want = slot_writes_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch:\n  expected %p\n  actual   %p", want, got);
          end
        end
        recv_gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (hold_request > 0) begin
        recv_hold = hold_request;
        hold_request = 0;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus helpers.
  function automatic range_item_t mk_item(logic hr, logic [63:0] b, logic [63:0] s,
                                          logic [63:0] p, logic l);
    range_item_t it;
    it.has_range = hr; it.base_addr = b; it.range_size = s; it.perm_word = p; it.last = l;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_SLOT_COUNT: cfg_slots = val[5:0];
      REG_FULL_EN:    cfg_full_en = val[0];
      REG_FULL_PERM:  cfg_full_perm = val;
      default: ;
    endcase
  endtask

  task automatic settle();
    do @(posedge clk);
    while (items_to_send.size() > 0 || in_valid || slot_writes_due.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(logic [5:0] sc, logic fe, logic [63:0] fp);
    settle();
    write_reg(REG_SLOT_COUNT, {58'd0, sc});
    write_reg(REG_FULL_EN, {63'd0, fe});
    write_reg(REG_FULL_PERM, fp);
  endtask

  // A legal list in shuffled order, with abutting neighbours now and then.
  task automatic queue_clean_list(int unsigned n, bit drop_last_flag);
    range_item_t lst[$];
    range_item_t t;
    logic [63:0] cursor, p0, p1, sz;
    int unsigned i, j;
    cursor = {$urandom_range(0, 32'h7fffffff), $urandom} & ~PAGE_MASK;
    cursor[62] = 1'b0;
    p0 = rand64();
    p1 = rand64();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1)) cursor += 64'd4096 * $urandom_range(1, 8);
      sz = 64'd4096 * $urandom_range(1, 16);
      lst.push_back(mk_item(1'b1, cursor, sz, ($urandom_range(0, 1) != 0) ? p0 : p1, 1'b0));
      cursor += sz;
    end
    for (i = n; i > 1; i--) begin
      j = $urandom_range(0, i - 1);
      t = lst[i-1]; lst[i-1] = lst[j]; lst[j] = t;
    end
    foreach (lst[k]) items_to_send.push_back(lst[k]);
    if (!drop_last_flag)
      items_to_send.push_back(mk_item(1'b0, rand64(), rand64(), rand64(), 1'b1));
  endtask

  task automatic queue_random_list();
    int unsigned kind, n;
    logic [63:0] b;
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
    if (kind < 65) begin
      queue_clean_list(n, 1'b0);
    end else if (kind < 72) begin
      items_to_send.push_back(mk_item(1'b0, rand64(), rand64(), rand64(), 1'b1));
    end else if (kind < 80) begin
      queue_clean_list(n, 1'b1);
      items_to_send.push_back(mk_item(1'b1, rand64(), rand64(), rand64(), 1'b0));
      items_to_send.push_back(mk_item(1'b1, rand64() & ~PAGE_MASK, 64'd0, rand64(), 1'b1));
    end else if (kind < 88) begin
      b = {$urandom_range(0, 32'hffffff), $urandom} & ~PAGE_MASK;
      items_to_send.push_back(mk_item(1'b1, b, 64'h8000, rand64(), 1'b0));
      queue_clean_list(n, 1'b1);
      items_to_send.push_back(mk_item(1'b1, b + 64'h1000, 64'h1000, rand64(), 1'b1));
    end else if (kind < 94) begin
      queue_clean_list(n, 1'b1);
      b = rand64() & ~PAGE_MASK;
      b[63] = 1'b1;
      items_to_send.push_back(mk_item(1'b1, b, rand64() & ~PAGE_MASK | 64'h8000_0000_0000_0000,
                                      rand64(), 1'b1));
    end else begin
      items_to_send.push_back(mk_item(1'b0, rand64(), rand64(), rand64(), 1'b0));
      queue_clean_list(n, 1'b0);
    end
  endtask

  initial begin
    int unsigned i, sent_lists;
    logic [63:0] fp;
    cfg_valid <= 1'b0; cfg_index <= REG_SLOT_COUNT; cfg_data <= '0;
    stored_ranges = 0; pending_error = ST_OK;
    cfg_slots = 6'd32; cfg_full_en = 1'b0; cfg_full_perm = '0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_SLOT_COUNT, 64'd32);

    // Directed lists.
    items_to_send.push_back(mk_item(1'b0, 64'd0, 64'd0, 64'd0, 1'b1));
    items_to_send.push_back(mk_item(1'b1, 64'd0, 64'hFFFF_FFFF_FFFF_F000,
                                    64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    items_to_send.push_back(mk_item(1'b1, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 64'd0, 1'b1));
    items_to_send.push_back(mk_item(1'b1, 64'h1000, 64'd0, 64'd1, 1'b1));
    items_to_send.push_back(mk_item(1'b1, 64'h1FFF, 64'hFFF, 64'd1, 1'b1));
    items_to_send.push_back(mk_item(1'b1, 64'h4000, 64'h2000, 64'd5, 1'b0));
    items_to_send.push_back(mk_item(1'b1, 64'h5000, 64'h1000, 64'd5, 1'b1));
    items_to_send.push_back(mk_item(1'b1, 64'h3000, 64'h1000, 64'd7, 1'b0));
    items_to_send.push_back(mk_item(1'b1, 64'h1000, 64'h2000, 64'd7, 1'b0));
    items_to_send.push_back(mk_item(1'b1, 64'h4000, 64'h1000, 64'd9, 1'b1));
    items_to_send.push_back(mk_item(1'b0, 64'd0, 64'd0, 64'd0, 1'b0));
    items_to_send.push_back(mk_item(1'b1, 64'h10000, 64'h1000, 64'd2, 1'b0));
    items_to_send.push_back(mk_item(1'b1, 64'h10000, 64'h1000, 64'd3, 1'b1));
    // One range more than the table holds.
    for (i = 0; i < 33; i++)
      items_to_send.push_back(mk_item(1'b1, 64'h1000 * (2 * i + 1), 64'h1000, 64'(i), 1'b0));
    items_to_send.push_back(mk_item(1'b0, 64'd0, 64'd0, 64'd0, 1'b1));
    queue_clean_list(15, 1'b0);

    set_config(6'd2, 1'b0, 64'd0);
    queue_clean_list(1, 1'b0);
    queue_clean_list(2, 1'b0);
    set_config(6'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    items_to_send.push_back(mk_item(1'b1, 64'h123, 64'd0, 64'd0, 1'b1));
    set_config(6'd63, 1'b1, rand64());
    queue_clean_list(3, 1'b0);
    set_config(6'd32, 1'b0, 64'd0);

    // Long receiver hold while lists keep arriving.
    @(negedge clk);
    hold_request = 400;
    for (i = 0; i < 4; i++) queue_clean_list(4, 1'b0);

    sent_lists = 0;
    while (sent_lists < 30) begin
      if (sent_lists % 10 == 0) begin
        fp = rand64();
        case ($urandom_range(0, 5))
          0: set_config(6'd1, 1'b0, fp);
          1: set_config(6'($urandom_range(3, 12)), 1'b0, fp);
          2: set_config(6'd32, 1'($urandom_range(0, 1)), fp);
          3: set_config(6'($urandom_range(33, 63)), 1'b0, fp);
          default: set_config(6'($urandom_range(8, 32)), 1'b0, fp);
        endcase
      end
      queue_random_list();
      sent_lists++;
    end
    settle();
    if (mismatches == 0) begin
      $display("range_list_to_tor_slot_compiler test passed");
    end else begin
      $display("range_list_to_tor_slot_compiler test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("range_list_to_tor_slot_compiler test failed");
    $finish;
  end

endmodule

`default_nettype wire
